[src/pcg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared constants, operation codes and the output permutation of the
// PCG32 XSH-RR generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

    localparam int STATE_W = 64;
    localparam int DRAW_W  = 32;
    localparam int VALUE_W = 53;
    localparam int FRAC_SHIFT = 2 * DRAW_W - VALUE_W;

    localparam logic [STATE_W-1:0] LCG_MULT      = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] RESET_STATE   = 64'h4d595df4d0f33173;
    localparam logic [STATE_W-1:0] RESET_INC     = 64'd1442695040888963407;
    localparam logic [STATE_W-1:0] RESET_SEQ     = 64'h853c49e6748fea9b;
    localparam logic [STATE_W-1:0] RESET_SEED    = 64'd0;

    localparam logic [1:0] OP_RESEED   = 2'd0;
    localparam logic [1:0] OP_RAW      = 2'd1;
    localparam logic [1:0] OP_BOUNDED  = 2'd2;
    localparam logic [1:0] OP_FRACTION = 2'd3;

    localparam logic CFG_SEED_STATE    = 1'b0;
    localparam logic CFG_SEED_SEQUENCE = 1'b1;

    // XSH-RR: xorshift the high bits, then rotate right by the top five bits.
    function automatic logic [DRAW_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
        logic [STATE_W-1:0]   shifted;
        logic [DRAW_W-1:0]    mixed;
        logic [4:0]           turn;
        logic [2*DRAW_W-1:0]  doubled;
        shifted = ((old >> 18) ^ old) >> 27;
        mixed   = shifted[DRAW_W-1:0];
        turn    = old[STATE_W-1:STATE_W-5];
        doubled = {mixed, mixed} >> turn;
        return doubled[DRAW_W-1:0];
    endfunction

endpackage

[src/pcg_lcg_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_lcg_step
// Advances the 64-bit LCG state by one step with a single shared 32x32
// multiplier used over three products and a final increment add.
// ----------------------------------------------------------------------------
module pcg_lcg_step
    import pcg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [STATE_W-1:0] state_in,
    input  logic [STATE_W-1:0] inc_in,
    output logic               done,
    output logic [STATE_W-1:0] result
);

    localparam int HALF_W = STATE_W / 2;
    localparam logic [2:0] PH_LAST = 3'd4;

    logic               busy_reg;
    logic [2:0]         phase_reg;
    logic               done_reg;
    logic [STATE_W-1:0] prod_reg;
    logic [STATE_W-1:0] acc_reg;
    logic [STATE_W-1:0] result_reg;
    logic [HALF_W-1:0]  op_a;
    logic [HALF_W-1:0]  op_b;
    logic [STATE_W-1:0] prod_next;

    always_comb begin
        unique case (phase_reg)
            3'd0: begin
                op_a = state_in[HALF_W-1:0];
                op_b = LCG_MULT[HALF_W-1:0];
            end
            3'd1: begin
                op_a = state_in[HALF_W-1:0];
                op_b = LCG_MULT[STATE_W-1:HALF_W];
            end
            default: begin
                op_a = state_in[STATE_W-1:HALF_W];
                op_b = LCG_MULT[HALF_W-1:0];
            end
        endcase
        prod_next = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 3'd0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= busy_reg && !start && (phase_reg == PH_LAST);
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 3'd0;
            end else if (busy_reg) begin
                phase_reg <= phase_reg + 3'd1;
                if (phase_reg == PH_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            prod_reg <= prod_next;
            unique case (phase_reg)
                3'd1: acc_reg <= prod_reg;
                3'd2, 3'd3: acc_reg[STATE_W-1:HALF_W] <=
                    acc_reg[STATE_W-1:HALF_W] + prod_reg[HALF_W-1:0];
                3'd4: result_reg <= acc_reg + inc_in;
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/pcg_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_divider
// Restoring radix-2 remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcg_divider
    import pcg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DRAW_W-1:0] dividend,
    input  logic [DRAW_W-1:0] divisor,
    output logic              done,
    output logic [DRAW_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DRAW_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DRAW_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DRAW_W-1:0] rem_reg;
    logic [DRAW_W-1:0] dvd_reg;
    logic [DRAW_W-1:0] dsr_reg;
    logic [DRAW_W:0]   trial;
    logic [DRAW_W:0]   diff;
    logic [DRAW_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[DRAW_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = (trial >= {1'b0, dsr_reg}) ? diff[DRAW_W-1:0] : trial[DRAW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DRAW_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[src/pcg32_xsh_rr_generator.sv]
`timescale 1ns / 1ps
// A raw draw and a fraction use the LCG step unit and its shared
// multiplier; a bounded draw also uses two passes of the remainder unit.
// One request is in work at a time; the next is taken while a result waits.
// Reset (synchronous, active low) loads the default state and increment.
// ----------------------------------------------------------------------------
// pcg32_xsh_rr_generator
// PCG32 generator with XSH-RR output, sequencing a shared LCG step unit and
// a shared remainder unit for reseed, raw, bounded and fraction requests.
// ----------------------------------------------------------------------------
module pcg32_xsh_rr_generator
    import pcg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [DRAW_W-1:0]  s_bound,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_value,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [STATE_W-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RESEED1 = 4'd1;
    localparam logic [3:0] S_RESEED2 = 4'd2;
    localparam logic [3:0] S_THRESH  = 4'd3;
    localparam logic [3:0] S_DRAW    = 4'd4;
    localparam logic [3:0] S_WAIT    = 4'd5;
    localparam logic [3:0] S_MOD     = 4'd6;
    localparam logic [3:0] S_OUT     = 4'd7;

    logic [3:0]         fsm_reg;
    logic [1:0]         op_reg;
    logic [DRAW_W-1:0]  bound_reg;
    logic [DRAW_W-1:0]  thresh_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic [DRAW_W-1:0]  first_reg;
    logic               second_reg;
    logic [VALUE_W-1:0] result_reg;
    logic [STATE_W-1:0] seed_state_reg;
    logic [STATE_W-1:0] seed_seq_reg;
    logic [STATE_W-1:0] lcg_state_reg;
    logic [STATE_W-1:0] lcg_inc_reg;
    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_value_reg;

    logic               lcg_start;
    logic               lcg_done;
    logic [STATE_W-1:0] lcg_result;
    logic               div_start;
    logic [DRAW_W-1:0]  div_dividend;
    logic [DRAW_W-1:0]  div_divisor;
    logic               div_done;
    logic [DRAW_W-1:0]  div_rem;
    logic               accept;
    logic               out_free;

    assign s_ready  = (fsm_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        lcg_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = draw_reg;
        div_divisor  = bound_reg;
        unique case (fsm_reg)
            S_IDLE: begin
                if (accept && s_operation == OP_RESEED) begin
                    lcg_start = 1'b1;
                end
                if (accept && s_operation == OP_BOUNDED && s_bound != '0) begin
                    div_start    = 1'b1;
                    div_dividend = '0 - s_bound;
                    div_divisor  = s_bound;
                end
            end
            S_RESEED1: lcg_start = lcg_done;
            S_DRAW:    lcg_start = 1'b1;
            S_WAIT: begin
                if (lcg_done && op_reg == OP_BOUNDED && bound_reg != '0
                        && draw_reg >= thresh_reg) begin
                    div_start = 1'b1;
                end
            end
            default: begin
                lcg_start = 1'b0;
            end
        endcase
    end

    pcg_lcg_step u_lcg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lcg_start),
        .state_in (lcg_state_reg),
        .inc_in   (lcg_inc_reg),
        .done     (lcg_done),
        .result   (lcg_result)
    );

    pcg_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_state_reg <= RESET_SEED;
            seed_seq_reg   <= RESET_SEQ;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SEED_STATE:    seed_state_reg <= cfg_data;
                CFG_SEED_SEQUENCE: seed_seq_reg   <= cfg_data;
                default:           seed_seq_reg   <= seed_seq_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= S_IDLE;
            lcg_state_reg <= RESET_STATE;
            lcg_inc_reg   <= RESET_INC;
            m_valid_reg   <= 1'b0;
            second_reg    <= 1'b0;
        end else begin
            if (fsm_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (fsm_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg     <= s_operation;
                        bound_reg  <= s_bound;
                        second_reg <= 1'b0;
                        if (s_operation == OP_RESEED) begin
                            lcg_state_reg <= '0;
                            lcg_inc_reg   <= {seed_seq_reg[STATE_W-2:0], 1'b1};
                            fsm_reg       <= S_RESEED1;
                        end else if (s_operation == OP_BOUNDED && s_bound != '0) begin
                            fsm_reg <= S_THRESH;
                        end else begin
                            fsm_reg <= S_DRAW;
                        end
                    end
                end
                S_RESEED1: begin
                    if (lcg_done) begin
                        lcg_state_reg <= lcg_result + seed_state_reg;
                        fsm_reg       <= S_RESEED2;
                    end
                end
                S_RESEED2: begin
                    if (lcg_done) begin
                        lcg_state_reg <= lcg_result;
                        fsm_reg       <= S_IDLE;
                    end
                end
                S_THRESH: begin
                    if (div_done) begin
                        thresh_reg <= div_rem;
                        fsm_reg    <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    draw_reg <= xsh_rr(lcg_state_reg);
                    fsm_reg  <= S_WAIT;
                end
                S_WAIT: begin
                    if (lcg_done) begin
                        lcg_state_reg <= lcg_result;
                        priority if (op_reg == OP_FRACTION) begin
                            if (second_reg) begin
                                result_reg <= {first_reg, draw_reg[DRAW_W-1:FRAC_SHIFT]};
                                fsm_reg    <= S_OUT;
                            end else begin
                                first_reg  <= draw_reg;
                                second_reg <= 1'b1;
                                fsm_reg    <= S_DRAW;
                            end
                        end else if (op_reg == OP_BOUNDED && bound_reg != '0) begin
                            if (draw_reg >= thresh_reg) begin
                                fsm_reg <= S_MOD;
                            end else begin
                                fsm_reg <= S_DRAW;
                            end
                        end else begin
                            result_reg <= VALUE_W'(draw_reg);
                            fsm_reg    <= S_OUT;
                        end
                    end
                end
                S_MOD: begin
                    if (div_done) begin
                        result_reg <= VALUE_W'(div_rem);
                        fsm_reg    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_value_reg <= result_reg;
                        fsm_reg     <= S_IDLE;
                    end
                end
                default: begin
                    fsm_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

endmodule
